// ===== src/aesbe_pkg.sv =====
package aesbe_pkg;

	typedef enum logic [2:0] {
		REG_KEY_0    = 3'd0,
		REG_KEY_1    = 3'd1,
		REG_KEY_2    = 3'd2,
		REG_KEY_3    = 3'd3,
		REG_KEY_SIZE = 3'd4
	} reg_index_t;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [127:0] block_t;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t RCON [10] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic word_t sub_word(input word_t w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

// ===== src/aesbe_round.sv =====
module aesbe_round
	import aesbe_pkg::*;
(
	input  block_t state,
	input  logic   mix,
	output block_t result
);

	function automatic byte_t xtime(input byte_t b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	byte_t s [16];
	byte_t t [16];
	byte_t m [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state[127 - 8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[c*4 + r] = SBOX[s[((c + r) % 4)*4 + r]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			m[c*4]   = xtime(t[c*4]) ^ xtime(t[c*4+1]) ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
			m[c*4+1] = t[c*4] ^ xtime(t[c*4+1]) ^ xtime(t[c*4+2]) ^ t[c*4+2] ^ t[c*4+3];
			m[c*4+2] = t[c*4] ^ t[c*4+1] ^ xtime(t[c*4+2]) ^ xtime(t[c*4+3]) ^ t[c*4+3];
			m[c*4+3] = xtime(t[c*4]) ^ t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ xtime(t[c*4+3]);
		end
		for (int i = 0; i < 16; i++) begin
			result[127 - 8*i -: 8] = mix ? m[i] : t[i];
		end
	end

endmodule

// ===== src/aes_block_encrypt.sv =====
// Channel   | Signals                                   | Handshake
// request   | start, plaintext_hi, plaintext_lo         | start & !busy
// result    | done, ciphertext_hi, ciphertext_lo        | done, one cycle
// config    | cfg_valid, cfg_index, cfg_data, cfg_ready | cfg_valid & cfg_ready
// A request keeps busy high through the initial key add, then one round per
// cycle through the shared round unit, the round key memory (four words wide,
// one row read a cycle) feeding each round; done follows in the next cycle.
// After a key change the first request is preceded by the schedule, one word
// a cycle. Reset clears the control state; the round key memory is not
// cleared. The receiver cannot stall: done pulses once.
module aes_block_encrypt
	import aesbe_pkg::*;
#(
	parameter int unsigned ROUND_KEY_DEPTH = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plaintext_hi,
	input  logic [63:0] plaintext_lo,
	output logic        done,
	output logic [63:0] ciphertext_hi,
	output logic [63:0] ciphertext_lo,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned ROWS = (ROUND_KEY_DEPTH + 3) / 4;
	localparam int unsigned AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_KEXP  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_ROUND = 4'b1000
	} state_t;

	state_t state_q;
	logic [63:0] key_q [4];
	logic [1:0]  key_size_q;
	logic        keys_ready_q;

	block_t      rk_mem [ROWS];
	block_t      rk_rd_q;
	logic [3:0]  rk_ok_q;

	// key schedule
	word_t       win_q [8];
	logic [5:0]  kidx_q;
	logic [2:0]  kmod_q;
	logic [3:0]  rcon_q;
	logic [3:0]  nk;
	logic [2:0]  nk_m1;
	logic [5:0]  total;
	logic [3:0]  nr;
	block_t      row_q;

	block_t      blk_q;
	logic [3:0]  rnd_q;
	block_t      round_out;

	always_comb begin
		case (key_size_q)
			2'd0: nk = 4'd4;
			2'd1: nk = 4'd6;
			default: nk = 4'd8;
		endcase
		nk_m1 = 3'(nk - 4'd1);
		nr = nk + 4'd6;
		total = {nr, 2'b00} + 6'd4;
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			key_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_KEY_0: key_q[0] <= cfg_data;
				REG_KEY_1: key_q[1] <= cfg_data;
				REG_KEY_2: key_q[2] <= cfg_data;
				REG_KEY_3: key_q[3] <= cfg_data;
				REG_KEY_SIZE: key_size_q <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
				default: ;
			endcase
		end
	end

	word_t kw_new;
	word_t kt;
	always_comb begin
		kt = win_q[nk_m1];
		if (kidx_q < 6'(nk)) begin
			kw_new = key_q[kidx_q[2:1]][kidx_q[0] ? 31 : 63 -: 32];
		end else begin
			if (kmod_q == 3'd0) begin
				kt = sub_word({kt[23:0], kt[31:24]}) ^ {RCON[rcon_q], 24'h0};
			end else if (nk == 4'd8 && kmod_q == 3'd4) begin
				kt = sub_word(kt);
			end
			kw_new = win_q[0] ^ kt;
		end
	end

	logic [5:0] rd_row;
	logic       rd_en;
	always_comb begin
		rd_en = 1'b0;
		rd_row = '0;
		if (state_q == ST_IDLE && start && keys_ready_q) begin
			rd_en = 1'b1;
		end else if (state_q == ST_KEXP && kidx_q == total - 6'd1) begin
			rd_en = 1'b1;
		end else if (state_q == ST_READ || state_q == ST_ROUND) begin
			rd_en = 1'b1;
			rd_row = {2'b00, rnd_q} + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_KEXP && kidx_q[1:0] == 2'd3 && (kidx_q >> 2) < 6'(ROWS)) begin
			rk_mem[kidx_q[AW+1:2]] <= {row_q[95:0], kw_new};
		end
		if (rd_en) begin
			// words at or beyond the store depth read as zero
			for (int c = 0; c < 4; c++)
				rk_ok_q[c] <= {rd_row, 2'(c)} < 8'(ROUND_KEY_DEPTH);
			if (rd_row < 6'(ROWS)) rk_rd_q <= rk_mem[rd_row[AW-1:0]];
		end
	end

	aesbe_round u_round (
		.state  (blk_q),
		.mix    (rnd_q != nr),
		.result (round_out)
	);

	block_t rk_eff;
	always_comb begin
		for (int c = 0; c < 4; c++)
			rk_eff[127 - 32*c -: 32] = rk_ok_q[c] ? rk_rd_q[127 - 32*c -: 32] : 32'h0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) blk_q <= {plaintext_hi, plaintext_lo};
		if (state_q == ST_KEXP) begin
			row_q <= {row_q[95:0], kw_new};
			for (int i = 0; i < 7; i++)
				win_q[i] <= (3'(i) == nk_m1) ? kw_new : win_q[i+1];
			win_q[7] <= (nk_m1 == 3'd7) ? kw_new : win_q[7];
		end
		if (state_q == ST_READ) blk_q <= blk_q ^ rk_eff;
		if (state_q == ST_ROUND) blk_q <= round_out ^ rk_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			keys_ready_q <= 1'b0;
			kidx_q <= '0;
			kmod_q <= '0;
			rcon_q <= '0;
			rnd_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) keys_ready_q <= 1'b0;
					if (start) begin
						rnd_q <= '0;
						kidx_q <= '0;
						kmod_q <= '0;
						rcon_q <= '0;
						state_q <= keys_ready_q ? ST_READ : ST_KEXP;
					end
				end
				ST_KEXP: begin
					kidx_q <= kidx_q + 6'd1;
					if (kidx_q >= 6'(nk)) begin
						if (kmod_q == nk_m1) begin
							kmod_q <= '0;
						end else begin
							kmod_q <= kmod_q + 3'd1;
						end
						if (kmod_q == 3'd0) rcon_q <= (rcon_q == 4'd9) ? 4'd0 : rcon_q + 4'd1;
					end else if (kidx_q == 6'(nk) - 6'd1) begin
						kmod_q <= '0;
					end
					if (kidx_q == total - 6'd1) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rnd_q <= 4'd1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == nr) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ciphertext_hi = blk_q[127:64];
	assign ciphertext_lo = blk_q[63:0];

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> keys_ready_q)
		else $error("result without key schedule");
	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= nr))
		else $error("round count overrun");

endmodule
